// ----- design/su_pkg.sv -----
`timescale 1ns / 1ps
package su_pkg;
	localparam int MaxItems = 32;
	localparam int IdxW = $clog2(MaxItems);
	localparam int CntW = $clog2(MaxItems + 1);
	localparam int ValW = 64;
	localparam int UCntW = 6;

	typedef struct packed {
		logic [ValW-1:0] value;
		logic            last;
	} req_t;

	typedef struct packed {
		logic [ValW-1:0]  value;
		logic             last;
		logic [UCntW-1:0] count;
		logic             ovf;
	} res_t;

	function automatic logic slt(input logic [ValW-1:0] a, input logic [ValW-1:0] b);
		slt = $signed(a) < $signed(b);
	endfunction
endpackage

// ----- design/su_fifo.sv -----
`timescale 1ns / 1ps
module su_fifo import su_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_data
);
	// two-entry queue between front and back
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- design/su_sorter.sv -----
`timescale 1ns / 1ps
module su_sorter import su_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);
	// insertion cell chain: cells stay sorted, duplicates are not inserted
	logic [ValW-1:0] cell_q [MaxItems];
	logic [MaxItems-1:0] occ_q;
	logic [CntW-1:0] fill_q;
	logic [UCntW-1:0] uniq_q;
	logic ovf_q;
	logic emit_q;
	logic [IdxW-1:0] rd_q;
	logic [MaxItems-1:0] lt, eqv;
	logic dup;
	res_t res;

	always_comb begin
		for (int i = 0; i < MaxItems; i++) begin
			lt[i]  = occ_q[i] && slt(cell_q[i], in_data.value);
			eqv[i] = occ_q[i] && cell_q[i] == in_data.value;
		end
	end
	assign dup = |eqv;
	assign in_ready = !emit_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && fill_q != CntW'(MaxItems) && !dup) begin
			for (int i = 0; i < MaxItems; i++) begin
				if (!lt[i]) begin
					if (i == 0) cell_q[i] <= in_data.value;
					else if (lt[i-1]) cell_q[i] <= in_data.value;
					else cell_q[i] <= cell_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			fill_q <= '0;
			uniq_q <= '0;
			ovf_q  <= 1'b0;
			emit_q <= 1'b0;
			rd_q   <= '0;
		end else if (!emit_q) begin
			if (in_valid) begin
				if (fill_q == CntW'(MaxItems)) ovf_q <= 1'b1;
				else begin
					fill_q <= fill_q + 1'b1;
					if (!dup) begin
						occ_q  <= {occ_q[MaxItems-2:0], 1'b1};
						uniq_q <= uniq_q + 1'b1;
					end
				end
				if (in_data.last) begin
					emit_q <= 1'b1;
					rd_q   <= '0;
				end
			end
		end else if (out_ready) begin
			if (res.last) begin
				emit_q <= 1'b0;
				occ_q  <= '0;
				fill_q <= '0;
				uniq_q <= '0;
				ovf_q  <= 1'b0;
			end else rd_q <= rd_q + 1'b1;
		end
	end

	always_comb begin
		res.value = cell_q[rd_q];
		res.last  = !(rd_q != IdxW'(MaxItems - 1) && occ_q[rd_q + 1'b1]);
		res.count = res.last ? uniq_q : '0;
		res.ovf   = ovf_q;
	end
	assign out_valid = emit_q;
	assign out_data  = res;
endmodule

// ----- design/su_outreg.sv -----
`timescale 1ns / 1ps
module su_outreg import su_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);
	res_t data_q;
	logic vld_q;
	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_q <= in_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (in_ready) vld_q <= in_valid;
	end
endmodule

// ----- design/sort_and_remove_duplicates.sv -----
`timescale 1ns / 1ps
// input: one item per cycle into a two-entry queue if not full; sorter takes one per cycle
// the insertion cell chain places each value on arrival, dropping repeats
// after the last item, the distinct values leave one per cycle while m_tready is high
// no input is taken by the chain while a batch is being emitted
// arst_n clears queue, cell occupancy, counts and output register
module sort_and_remove_duplicates import su_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // item_value
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // unique_value
	output logic        m_tlast,   // last_out
	output logic [6:0]  m_tuser    // unique_count[5:0], overflowed
);
	req_t qin, qout;
	logic qv, qr, sv, sr;
	res_t sres, ores;

	assign qin.value = s_tdata;
	assign qin.last  = s_tlast;

	su_fifo u_fifo (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(qin),
		.out_valid(qv), .out_ready(qr), .out_data(qout));
	su_sorter u_sorter (.clk, .arst_n, .in_valid(qv), .in_ready(qr), .in_data(qout),
		.out_valid(sv), .out_ready(sr), .out_data(sres));
	su_outreg u_out (.clk, .arst_n, .in_valid(sv), .in_ready(sr), .in_data(sres),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(ores));

	assign m_tdata = ores.value;
	assign m_tlast = ores.last;
	assign m_tuser = {ores.ovf, ores.count};
endmodule

// ----- design/su_checker.sv -----
`timescale 1ns / 1ps
module su_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic [6:0]  m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_cnt0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[5:0] == 6'd0) else $error("count on non-final");
	a_cntl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[5:0] != 6'd0) else $error("zero count on final");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
		$signed(m_tdata) > $signed($past(m_tdata))) else $error("not ascending");
endmodule

bind sort_and_remove_duplicates su_checker u_su_checker (.*);

// ----- bench/sort_and_remove_duplicates_tb.sv -----
`timescale 1ns / 1ps
module sort_and_remove_duplicates_tb;
	import su_pkg::*;

	localparam int StallLimit = 20000;

	typedef struct {
		logic [ValW-1:0]  value;
		logic             last;
		logic [UCntW-1:0] count;
		logic             ovf;
	} uniq_res_t;

	class unique_sorter_sb;
		logic [ValW-1:0] batch_vals[$];
		logic            batch_ovf;
		uniq_res_t       pending[$];
		int              errors;

		function void note_request(logic [ValW-1:0] v, logic last);
			logic [ValW-1:0] sorted[$];
			logic [ValW-1:0] tmp;
			uniq_res_t r;
			int j;
			if (batch_vals.size() < MaxItems) batch_vals.push_back(v);
			else batch_ovf = 1'b1;
			if (!last) return;
			sorted = batch_vals;
			for (int i = 1; i < sorted.size(); i++) begin
				tmp = sorted[i];
				j = i;
				while (j > 0 && $signed(tmp) < $signed(sorted[j-1])) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = tmp;
			end
			for (int k = 0; k < sorted.size(); k++) begin
				if (k > 0 && sorted[k] == sorted[k-1]) continue;
				r.value = sorted[k];
				r.last = 1'b0;
				r.count = '0;
				r.ovf = batch_ovf;
				pending.push_back(r);
			end
			pending[pending.size()-1].last = 1'b1;
			j = 0;
			for (int k = 0; k < sorted.size(); k++)
				if (k == 0 || sorted[k] != sorted[k-1]) j++;
			pending[pending.size()-1].count = UCntW'(j);
			batch_vals.delete();
			batch_ovf = 1'b0;
		endfunction

		function void check_result(logic [ValW-1:0] v, logic last, logic [6:0] user);
			uniq_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result value=%h", v);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$error("unique_value expected %h actual %h", e.value, v); errors++;
			end
			if (last !== e.last) begin
				$error("last_out expected %0d actual %0d", e.last, last); errors++;
			end
			if (user[5:0] !== e.count) begin
				$error("unique_count expected %0d actual %0d", e.count, user[5:0]); errors++;
			end
			if (user[6] !== e.ovf) begin
				$error("overflowed expected %0d actual %0d", e.ovf, user[6]); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // item_value
	logic        s_tlast;   // is_last
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // unique_value
	logic        m_tlast;   // last_out
	logic [6:0]  m_tuser;   // unique_count[5:0], overflowed

	unique_sorter_sb sb;
	int  idle_cycles;
	bit  hold_sink;
	int  sent;

	sort_and_remove_duplicates i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("sort_and_remove_duplicates_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_request(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
	end

	task automatic send_item(logic [63:0] v, logic last);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	function automatic logic [63:0] rand_val(int pool);
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'($signed($urandom_range(0, pool)) - pool / 2);
			2: return {1'b1, 63'($urandom_range(0, pool))};
			default: return {32'h0, 32'($urandom_range(0, pool))};
		endcase
	endfunction

	task automatic send_batch(int len, int pool);
		for (int i = 0; i < len; i++) send_item(rand_val(pool), i == len - 1);
	endtask

	// wait first so the last accepted request is already in the scoreboard
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// sink side: random stalls, or a long hold when asked
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		sb = new();
		sb.batch_ovf = 1'b0;
		sb.errors = 0;
		idle_cycles = 0;
		sent = 0;
		hold_sink = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single item, extremes, repeats, full store, overflow
		send_item(64'h8000_0000_0000_0000, 1'b1);
		send_item(64'h7fff_ffff_ffff_ffff, 1'b0);
		send_item(64'h8000_0000_0000_0000, 1'b0);
		send_item(64'hffff_ffff_ffff_ffff, 1'b0);
		send_item(64'h0, 1'b0);
		send_item(64'h7fff_ffff_ffff_ffff, 1'b1);
		send_item(64'h5, 1'b0);
		send_item(64'h5, 1'b1);
		for (int i = 0; i < MaxItems; i++) send_item(64'(MaxItems - i), i == MaxItems - 1);
		for (int i = 0; i < MaxItems + 3; i++) send_item(64'(i * 3), i == MaxItems + 2);
		wait_drained();

		// long sink hold while the source keeps offering
		hold_sink = 1'b1;
		send_batch(MaxItems, 1000);
		send_batch(20, 1000);
		send_batch(10, 1000);
		wait_drained();

		while (sent < 500) begin
			case ($urandom_range(0, 9))
				0: send_batch($urandom_range(MaxItems + 1, MaxItems + 6), 40);
				1: send_batch(MaxItems, 1 << 30);
				2: send_batch(1, 1 << 30);
				default: send_batch($urandom_range(1, 16), $urandom_range(1, 20));
			endcase
			if ($urandom_range(0, 15) == 0) wait_drained();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("sort_and_remove_duplicates_tb: done, clean");
		else $display("sort_and_remove_duplicates_tb: done, errors");
		$finish;
	end
endmodule
